// ===== sv/sswq_pkg.sv =====
`timescale 1ns / 1ps

package sswq_pkg;

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_WOKEN    = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef struct packed {
        logic        command;
        logic [7:0]  thread_id;
        logic [31:0] sleep_ticks;
        logic [5:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  woken_id;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [63:0] wake;
        logic [7:0]  thread;
        logic [5:0]  prio;
    } t_entry;

endpackage

// ===== sv/sorted_sleep_wakeup_queue.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+-------------------------------------
// in       | in  | i_in_valid / o_in_stall | command, thread_id, sleep_ticks, prio
// out      | out | o_out_valid / i_out_stall | result_kind, woken_id, last
//
// One transaction at a time. A sleep request walks the queue from the tail, one
// entry per cycle through the entry RAM's one read port and one write port; the
// last step loads the result. A tick pops one due entry per cycle from the head
// while the output is not stalled. A full queue rejects without a walk.
// Reset clears the tick count and empties the queue; RAM contents are not cleared.
// A stall on the output holds the sequencer until the result register frees.

module sorted_sleep_wakeup_queue
    import sswq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_WAKE,
        S_RESULT
    } t_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    endfunction

    t_state        r_state, n_state;
    logic [63:0]   r_tick, n_tick;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    t_entry        r_new, n_new;
    logic          r_pend, n_pend;
    logic [7:0]    r_pend_id, n_pend_id;
    t_kind         r_res_kind, n_res_kind;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          ram_we;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    t_entry        rd_entry;

    logic          accept;
    logic          out_free;
    logic          emit;
    t_out_item     emit_item;
    logic          new_before;
    logic          wake_hit;

    sswq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(r_wr_ptr),
        .i_wr_data(ram_wdata),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

    assign rd_entry   = t_entry'(ram_rdata);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign new_before = (r_new.wake < rd_entry.wake) ||
                        ((r_new.wake == rd_entry.wake) && (r_new.prio > rd_entry.prio));
    assign wake_hit   = (r_count != '0) && (rd_entry.wake <= r_tick);

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_count    = r_count;
        n_left     = r_left;
        n_head     = r_head;
        n_tail     = r_tail;
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_new      = r_new;
        n_pend     = r_pend;
        n_pend_id  = r_pend_id;
        n_res_kind = r_res_kind;
        ram_we     = 1'b0;
        ram_wdata  = r_new;
        ram_raddr  = r_head;
        emit       = 1'b0;
        emit_item  = '{result_kind: KIND_NONE, woken_id: 8'd0, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = (i_in_data.command == CMD_TICK) ? r_head : ptr_dec(r_tail);
                if (accept) begin
                    if (i_in_data.command == CMD_TICK) begin
                        n_tick  = r_tick + 64'd1;
                        n_pend  = 1'b0;
                        n_state = S_WAKE;
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_res_kind = KIND_REJECTED;
                        n_state    = S_RESULT;
                    end else begin
                        n_new.wake   = r_tick + 64'(i_in_data.sleep_ticks);
                        n_new.thread = i_in_data.thread_id;
                        n_new.prio   = i_in_data.priority_req;
                        n_wr_ptr     = r_tail;
                        n_rd_ptr     = ptr_dec(r_tail);
                        n_left       = r_count;
                        n_state      = S_INS;
                    end
                end
            end
            S_INS: begin
                ram_raddr = ptr_dec(r_rd_ptr);
                ram_we    = 1'b1;
                if ((r_left == '0) || !new_before) begin
                    // drop the new entry into the hole
                    ram_wdata  = r_new;
                    n_count    = r_count + CW'(1);
                    n_tail     = ptr_inc(r_tail);
                    n_res_kind = KIND_ACCEPTED;
                    n_state    = S_RESULT;
                end else begin
                    // shift the later entry one place toward the tail
                    ram_wdata = ram_rdata;
                    n_wr_ptr  = r_rd_ptr;
                    n_rd_ptr  = ptr_dec(r_rd_ptr);
                    n_left    = r_left - CW'(1);
                end
            end
            S_WAKE: begin
                if (wake_hit) begin
                    // hold the woken id until the next entry tells whether it is last
                    if (!r_pend || out_free) begin
                        emit      = r_pend;
                        emit_item = '{result_kind: KIND_WOKEN, woken_id: r_pend_id,
                                      last: 1'b0};
                        n_pend    = 1'b1;
                        n_pend_id = rd_entry.thread;
                        n_head    = ptr_inc(r_head);
                        n_count   = r_count - CW'(1);
                    end
                end else if (out_free) begin
                    emit = 1'b1;
                    if (r_pend) begin
                        emit_item = '{result_kind: KIND_WOKEN, woken_id: r_pend_id,
                                      last: 1'b1};
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
                ram_raddr = n_head;
            end
            S_RESULT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = '{result_kind: r_res_kind, woken_id: 8'd0, last: 1'b1};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = emit || (r_out_valid && i_out_stall);
        n_out       = emit ? emit_item : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_left     <= n_left;
        r_wr_ptr   <= n_wr_ptr;
        r_rd_ptr   <= n_rd_ptr;
        r_new      <= n_new;
        r_pend_id  <= n_pend_id;
        r_res_kind <= n_res_kind;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/sswq_ram.sv =====
`timescale 1ns / 1ps

module sswq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
